// ===== rtl/core/utxq_pkg.sv =====
// Package for the transmit descriptor queue.
// Holds the fixed field widths, function codes and shared types; no dependencies.
`default_nettype none

package utxq_pkg;

  localparam int ADDR_W    = 32;
  localparam int BUF_LEN_W = 16;
  localparam int CHUNK_W   = 5;

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [BUF_LEN_W-1:0] buf_len_t;
  typedef logic [CHUNK_W-1:0]   chunk_t;

  typedef enum logic {
    FUNC_ENQ  = 1'b0,
    FUNC_FILL = 1'b1
  } func_t;

  localparam chunk_t CHUNK_RESET = 5'd15;
  localparam chunk_t CHUNK_MAX   = 5'd16;
  localparam chunk_t CHUNK_MIN   = 5'd1;

  typedef struct packed {
    chunk_t len;
    addr_t  next_addr;
    logic   done;
  } fill_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/utxq_if.sv =====
// Channel interfaces for the transmit descriptor queue: input and result.
// Depends on utxq_pkg for the payload types.
`default_nettype none

interface utxq_in_if;
  logic               valid;
  logic               ready;
  utxq_pkg::func_t    func;
  logic               port;
  utxq_pkg::addr_t    buf_addr;
  utxq_pkg::buf_len_t buf_len;

  modport source (output valid, func, port, buf_addr, buf_len, input ready);
  modport sink (input valid, func, port, buf_addr, buf_len, output ready);
endinterface

interface utxq_out_if;
  logic             valid;
  logic             ready;
  logic             accepted;
  utxq_pkg::addr_t  chunk_addr;
  utxq_pkg::chunk_t chunk_len;
  logic             head_done;

  modport source (output valid, accepted, chunk_addr, chunk_len, head_done, input ready);
  modport sink (input valid, accepted, chunk_addr, chunk_len, head_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/utxq_fill.sv =====
// Fill step arithmetic: clamps the chunk limit, sizes the chunk and advances the head.
// Depends on utxq_pkg.
`default_nettype none

module utxq_fill #(
  parameter int LEN_BITS = 16
) (
  input  utxq_pkg::chunk_t    limit_cfg,
  input  utxq_pkg::addr_t     addr,
  input  logic [LEN_BITS-1:0] rem,
  output logic [LEN_BITS-1:0] next_rem,
  output utxq_pkg::fill_res_t res
);
  import utxq_pkg::*;

  chunk_t              lim;
  logic [LEN_BITS-1:0] lim_ext;
  logic                take_all;
  chunk_t              n;

  always_comb begin
    if (limit_cfg == '0) begin
      lim = CHUNK_MIN;
    end else if (limit_cfg > CHUNK_MAX) begin
      lim = CHUNK_MAX;
    end else begin
      lim = limit_cfg;
    end
    lim_ext       = LEN_BITS'(lim);
    take_all      = (rem <= lim_ext);
    n             = take_all ? rem[CHUNK_W-1:0] : lim;
    next_rem      = rem - LEN_BITS'(n);
    res.len       = n;
    res.next_addr = addr + ADDR_W'(n);
    res.done      = take_all;
  end

endmodule

`default_nettype wire

// ===== rtl/core/uart_tx_descriptor_queue.sv =====
// Transmit descriptor queue top level: per-port descriptor FIFOs and fill steps.
// Depends on utxq_pkg, utxq_if and utxq_fill.
//
// Each port keeps a FIFO of up to QUEUE_SLOTS buffer descriptors. An enqueue
// transaction appends a descriptor (refused with accepted low when the port's
// queue is full) and then runs a fill step on that port; a fill transaction runs
// a fill step only. A fill step reports up to chunk_limit bytes (clamped to the
// range 1 to 16) from the head descriptor and pops it once it is used up. One
// transaction is taken every cycle while the result channel does not stall; a
// result passes through the input register and then the result register, as the
// head and count registers of a port are read and updated in the same cycle. A
// transaction can still enter an empty input register while a result waits.
`default_nettype none

module uart_tx_descriptor_queue #(
  parameter int QUEUE_SLOTS = 10,
  parameter int NUM_PORTS   = 2,
  parameter int LEN_BITS    = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  utxq_pkg::chunk_t cfg_data,
  utxq_in_if.sink          in_ch,
  utxq_out_if.source       out_ch
);
  import utxq_pkg::*;

  localparam int PIW   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int SIW   = $clog2(QUEUE_SLOTS);
  localparam int CW    = $clog2(QUEUE_SLOTS + 1);
  localparam int SUMW  = CW + 1;
  localparam int EXT_W = LEN_BITS + BUF_LEN_W;

  chunk_t chunk_limit_r;

  logic     in_valid_r;
  func_t    in_func_r;
  logic     in_port_r;
  addr_t    in_addr_r;
  buf_len_t in_len_r;

  logic   out_valid_r;
  logic   out_accepted_r;
  addr_t  out_addr_r;
  chunk_t out_len_r;
  logic   out_done_r;

  logic [SIW-1:0]      head_r [NUM_PORTS];
  logic [CW-1:0]       cnt_r  [NUM_PORTS];
  addr_t               addr_r [NUM_PORTS][QUEUE_SLOTS];
  logic [LEN_BITS-1:0] rem_r  [NUM_PORTS][QUEUE_SLOTS];

  logic                advance;
  logic                port_ok;
  logic [PIW-1:0]      pi;
  logic [SIW-1:0]      head;
  logic [CW-1:0]       cnt;
  logic                full;
  logic                do_enq;
  logic                do_fill;
  logic [SUMW-1:0]     tail_sum;
  logic [SIW-1:0]      tail;
  logic [CW-1:0]       cnt_after;
  logic                have;
  logic                pop;
  logic [SIW-1:0]      head_inc;
  logic [EXT_W-1:0]    len_ext;
  logic [LEN_BITS-1:0] len_in;
  addr_t               hd_addr;
  logic [LEN_BITS-1:0] hd_rem;
  logic [LEN_BITS-1:0] next_rem;
  fill_res_t           fres;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_comb begin
    port_ok   = (int'(in_port_r) < NUM_PORTS);
    pi        = PIW'(in_port_r);
    head      = head_r[pi];
    cnt       = cnt_r[pi];
    full      = (cnt >= CW'(QUEUE_SLOTS));
    do_enq    = port_ok && (in_func_r == FUNC_ENQ) && !full;
    do_fill   = port_ok && ((in_func_r == FUNC_FILL) || !full);
    tail_sum  = SUMW'(head) + SUMW'(cnt);
    if (tail_sum >= SUMW'(QUEUE_SLOTS)) begin
      tail = SIW'(tail_sum - SUMW'(QUEUE_SLOTS));
    end else begin
      tail = SIW'(tail_sum);
    end
    cnt_after = cnt + CW'(do_enq);
    have      = do_fill && (cnt_after != '0);
    len_ext   = EXT_W'(in_len_r);
    len_in    = len_ext[LEN_BITS-1:0];
    if (cnt == '0) begin
      hd_addr = in_addr_r;
      hd_rem  = len_in;
    end else begin
      hd_addr = addr_r[pi][head];
      hd_rem  = rem_r[pi][head];
    end
    pop      = have && fres.done;
    head_inc = (head == SIW'(QUEUE_SLOTS - 1)) ? '0 : head + SIW'(1);
  end

  utxq_fill #(
    .LEN_BITS (LEN_BITS)
  ) u_fill (
    .limit_cfg (chunk_limit_r),
    .addr      (hd_addr),
    .rem       (hd_rem),
    .next_rem  (next_rem),
    .res       (fres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_limit_r <= CHUNK_RESET;
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        chunk_limit_r <= cfg_data;
      end
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance && port_ok) begin
        cnt_r[pi] <= cnt_after - CW'(pop);
        if (pop) begin
          head_r[pi] <= head_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      in_func_r <= in_ch.func;
      in_port_r <= in_ch.port;
      in_addr_r <= in_ch.buf_addr;
      in_len_r  <= in_ch.buf_len;
    end
    if (advance) begin
      out_accepted_r <= do_fill;
      out_addr_r     <= have ? hd_addr : '0;
      out_len_r      <= have ? fres.len : '0;
      out_done_r     <= pop;
      if (do_enq && (cnt != '0)) begin
        addr_r[pi][tail] <= in_addr_r;
        rem_r[pi][tail]  <= len_in;
      end
      if (have) begin
        addr_r[pi][head] <= fres.next_addr;
        rem_r[pi][head]  <= next_rem;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.accepted   = out_accepted_r;
  assign out_ch.chunk_addr = out_addr_r;
  assign out_ch.chunk_len  = out_len_r;
  assign out_ch.head_done  = out_done_r;

endmodule

`default_nettype wire
